// ----- rtl/spq_pkg.sv -----
// Package for the sorted priority queue.
// Holds the request, result, entry and cell control types and the sizing constants.
// Depends on nothing.
package spq_pkg;

  localparam int CAPACITY = 32;
  localparam int PRIO_W   = 8;
  localparam int DATA_W   = 8;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_READ_FWD = 2'd1,
    CMD_READ_BWD = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_HOLD    = 4'b0001,
    OP_INSERT  = 4'b0010,
    OP_ROT_FWD = 4'b0100,
    OP_ROT_BWD = 4'b1000
  } cell_op_e;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  data_char;
    logic [7:0]  priority_req;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  position;
    logic [7:0]  data_char_res;
    logic [7:0]  priority_res;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic   valid;
    logic   gt;
    entry_t entry;
  } link_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   new_entry;
  } cell_ctrl_t;

endpackage

// ----- rtl/sorted_priority_queue.sv -----
// Channel   Handshake             Payload  Direction
// request   start / busy          req_i    in
// result    res_valid_o (strobe)  res_o    out
//
// An insert leaves busy low; a new request may follow in the next cycle.
// A read of n entries keeps busy high and gives n results, one result per cycle, as
// the cell chain rotates; an empty read or any insert gives one result.
// Reset clears the valid bits and the count at once; no clearing pass is needed.
// Each result stays on res_o for one cycle and is never held back.
module sorted_priority_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::req_t req_i,
  output logic          res_valid_o,
  output spq_pkg::res_t res_o
);
  import spq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic               dir_q, dir_d;
  logic               res_valid_q, res_valid_d;
  res_t               res_q, res_d;
  cell_ctrl_t         ctrl;
  link_t              links [CAPACITY];
  logic               is_tail [CAPACITY];
  entry_t             head, tail;
  entry_t             sel;
  logic               accept;
  logic               is_last;

  assign head = links[0].entry;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t left, right;
    if (i == 0) begin : g_first
      assign left = '{valid: 1'b1, gt: 1'b0, entry: tail};
    end else begin : g_mid
      assign left = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right   = '{valid: 1'b0, gt: 1'b0, entry: head};
      assign is_tail[i] = links[i].valid;
    end else begin : g_inner
      assign right   = links[i+1];
      assign is_tail[i] = links[i].valid && !links[i+1].valid;
    end
    spq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .left_i (left),
      .right_i(right),
      .head_i (head),
      .link_o (links[i])
    );
  end

  always_comb begin
    tail = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (is_tail[i]) begin
        tail = tail | links[i].entry;
      end
    end
  end

  assign accept  = start && !busy;
  assign sel     = dir_q ? tail : head;
  assign is_last = (CNT_W'(idx_q + 1'b1) == cnt_q);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    idx_d         = idx_q;
    dir_d         = dir_q;
    res_valid_d   = 1'b0;
    res_d         = '0;
    res_d.last    = 1'b1;
    ctrl.op       = OP_HOLD;
    ctrl.new_entry = '{data: req_i.data_char, prio: req_i.priority_req[PRIO_W-1:0]};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.command)
            CMD_INSERT: begin
              res_valid_d = 1'b1;
              if (cnt_q == CNT_W'(CAPACITY)) begin
                res_d.status = ST_FULL;
              end else begin
                res_d.status = ST_ACCEPTED;
                ctrl.op      = OP_INSERT;
                cnt_d        = cnt_q + 1'b1;
              end
            end
            CMD_READ_FWD, CMD_READ_BWD: begin
              if (cnt_q == '0) begin
                res_valid_d  = 1'b1;
                res_d.status = ST_EMPTY;
              end else begin
                state_d = S_READ;
                idx_d   = '0;
                dir_d   = (req_i.command == CMD_READ_BWD);
              end
            end
            default: begin
              res_valid_d = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        res_valid_d         = 1'b1;
        res_d.status        = ST_DATA;
        res_d.position      = POS_W'(idx_q) + 1'b1;
        res_d.data_char_res = sel.data;
        res_d.priority_res  = 8'(sel.prio);
        res_d.last          = is_last;
        ctrl.op             = dir_q ? OP_ROT_BWD : OP_ROT_FWD;
        idx_d               = idx_q + 1'b1;
        if (is_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      dir_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      dir_q       <= dir_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy        = (state_q == S_READ);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/spq_cell.sv -----
// One cell of the sorted queue chain: holds one entry and its valid bit.
// Shifts, inserts or rotates under the shared control word.
// Depends on spq_pkg.
module spq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::link_t     left_i,
  input  spq_pkg::link_t     right_i,
  input  spq_pkg::entry_t    head_i,
  output spq_pkg::link_t     link_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;
  logic   valid_q, valid_d;
  logic   gt;

  assign gt = valid_q && (entry_q.prio > ctrl_i.new_entry.prio);

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (left_i.gt) begin
          entry_d = left_i.entry;
          valid_d = 1'b1;
        end else if ((gt || !valid_q) && left_i.valid) begin
          entry_d = ctrl_i.new_entry;
          valid_d = 1'b1;
        end
      end
      OP_ROT_FWD: begin
        if (valid_q) begin
          entry_d = right_i.valid ? right_i.entry : head_i;
        end
      end
      OP_ROT_BWD: begin
        if (valid_q) begin
          entry_d = left_i.entry;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign link_o = '{valid: valid_q, gt: gt, entry: entry_q};

endmodule

// ----- rtl/spq_checker.sv -----
// Port-level checks for the sorted priority queue.
// Bound to sorted_priority_queue; depends on spq_pkg.
module spq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input spq_pkg::req_t req_i,
  input logic          res_valid_o,
  input spq_pkg::res_t res_o
);
  import spq_pkg::*;

  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != ST_DATA |-> res_o.last && res_o.position == '0)
    else $error("Status result is not a single last result.");

  a_stream_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == ST_DATA && !res_o.last |=> res_valid_o)
    else $error("Readout stream has a gap.");

  a_insert_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.command == CMD_INSERT |=>
      res_valid_o && (res_o.status == ST_ACCEPTED || res_o.status == ST_FULL))
    else $error("Insert request got no status result.");

  a_read_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (req_i.command == CMD_READ_FWD || req_i.command == CMD_READ_BWD)
      |=> busy || (res_valid_o && res_o.status == ST_EMPTY))
    else $error("Read request neither streamed nor reported empty.");

  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o && res_o.last && res_o.status == ST_DATA)
    else $error("Readout ended without a last entry result.");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .req_i      (req_i),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);
